// File: src/ofr_pkg.sv
// Overlapping window framer: shared constants, widths and types.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package ofr_pkg;

  localparam int HopLength   = 10;
  localparam int NumSegments = 5;
  localparam int AvgDepth    = 4;
  localparam int SampleW     = 16;
  localparam int AvgW        = 24;
  localparam int FracBits    = 8;

  localparam int WindowLen = NumSegments * HopLength;
  localparam int AddrW     = $clog2(WindowLen);
  localparam int LeftW     = $clog2(WindowLen + 1);
  localparam int OffW      = $clog2(HopLength);
  localparam int SegW      = (NumSegments > 1) ? $clog2(NumSegments) : 1;
  localparam int FillW     = $clog2(NumSegments + 1);
  localparam int PtrW      = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;
  localparam int CntW      = $clog2(AvgDepth + 1);
  localparam int SumW      = SampleW + CntW;
  localparam int DivW      = SumW + FracBits;
  localparam int StepW     = $clog2(DivW + 1);

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // One classified sample, front to back.
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [AddrW-1:0]   addr;
    logic               emit;
    logic [AddrW-1:0]   start_addr;
    logic [SumW-1:0]    sum;
    logic [CntW-1:0]    cnt;
  } ofr_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ofr_div_status_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_DRAIN
  } ofr_back_state_e;

endpackage

`default_nettype wire

// File: src/ofr_fifo.sv
// Short queue of classified samples between front and back.
// Depends on ofr_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module ofr_fifo
  import ofr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ofr_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output ofr_entry_t head_o,
  output logic       empty_o
);

  ofr_entry_t            mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/ofr_front.sv
// Front end: accepts samples, tracks segment fill and the value ring,
// and tags each sample with its store address and window action. Uses ofr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ofr_front
  import ofr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  output logic               push_o,
  output ofr_entry_t         push_data_o,
  input  logic               full_i
);

  logic [SegW-1:0]    seg_q, seg_d;
  logic [OffW-1:0]    off_q, off_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [SampleW-1:0] ring_q [AvgDepth];
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic               accept, hop_end, emit;
  logic [SegW-1:0]    seg_next;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign hop_end    = (off_q == OffW'(HopLength - 1));
  assign seg_next   = (seg_q == SegW'(NumSegments - 1)) ? '0 : seg_q + 1'b1;
  // fill count reaches zero on the hop that completes the first window
  assign emit       = hop_end && (fill_q <= FillW'(1));

  always_comb begin
    seg_d  = seg_q;
    off_d  = off_q;
    fill_d = fill_q;
    ptr_d  = ptr_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    if (accept) begin
      off_d = hop_end ? '0 : off_q + 1'b1;
      if (hop_end) begin
        seg_d = seg_next;
        if (fill_q != '0) begin
          fill_d = fill_q - 1'b1;
        end
      end
      if (emit) begin
        sum_d = sum_q - SumW'(ring_q[ptr_q]) + SumW'(sample_i);
        ptr_d = (ptr_q == PtrW'(AvgDepth - 1)) ? '0 : ptr_q + 1'b1;
        if (cnt_q != CntW'(AvgDepth)) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    push_o                 = accept;
    push_data_o.sample     = sample_i;
    push_data_o.addr       = AddrW'(int'(seg_q) * HopLength + int'(off_q));
    push_data_o.emit       = emit;
    push_data_o.start_addr = AddrW'(int'(seg_next) * HopLength);
    push_data_o.sum        = sum_d;
    push_data_o.cnt        = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= '0;
      off_q  <= '0;
      fill_q <= FillW'(NumSegments);
      ptr_q  <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      for (int k = 0; k < AvgDepth; k++) begin
        ring_q[k] <= '0;
      end
    end else begin
      seg_q  <= seg_d;
      off_q  <= off_d;
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      if (accept && emit) begin
        ring_q[ptr_q] <= sample_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/ofr_div.sv
// Restoring divider, one quotient bit per cycle, for the ring average.
// Uses ofr_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module ofr_div
  import ofr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivW-1:0]  dividend_i,
  input  logic [CntW-1:0]  divisor_i,
  output logic [DivW-1:0]  quotient_o,
  output ofr_div_status_t  status_o
);

  logic [DivW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dvs_q;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW:0]    shifted;
  logic             fits;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      step_d = StepW'(DivW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d  = fits ? CntW'(shifted - {1'b0, dvs_q}) : shifted[CntW-1:0];
      quo_d  = {quo_q[DivW-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign status_o   = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

// File: src/ofr_back.sv
// Back end: writes samples into the window store and drains the window
// through the output register. Uses ofr_pkg and ofr_div.
`timescale 1ns / 1ps
`default_nettype none

module ofr_back
  import ofr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ofr_entry_t         head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] window_sample_o,
  output logic               last_of_window_o,
  output logic [AvgW-1:0]    average_value_o
);

  ofr_back_state_e    state_q, state_d;
  logic [SampleW-1:0] store [WindowLen];
  logic [SampleW-1:0] rdata_q;
  logic [AddrW-1:0]   raddr_q, raddr_d;
  logic [LeftW-1:0]   left_q, left_d;
  logic               rd_pend_q, rd_pend_d;
  logic               rd_last_q, rd_last_d;
  logic               issue, move, div_start;
  logic [DivW-1:0]    quotient;
  ofr_div_status_t    div_st;

  ofr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({head_i.sum, FracBits'(0)}),
    .divisor_i  (head_i.cnt),
    .quotient_o (quotient),
    .status_o   (div_st)
  );

  // the last sample waits in the read register until the average is ready
  assign move  = rd_pend_q && (!out_valid_o || out_ready_i) && (!rd_last_q || div_st.done);
  assign issue = (state_q == BK_DRAIN) && (left_q != '0) && (!rd_pend_q || move);

  always_comb begin
    state_d   = state_q;
    raddr_d   = raddr_q;
    left_d    = left_q;
    rd_pend_d = rd_pend_q;
    rd_last_d = rd_last_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.emit) begin
            div_start = 1'b1;
            raddr_d   = head_i.start_addr;
            left_d    = LeftW'(WindowLen);
            state_d   = BK_DRAIN;
          end
        end
      end
      BK_DRAIN: begin
        if (move) begin
          rd_pend_d = 1'b0;
          if (rd_last_q) begin
            state_d = BK_IDLE;
          end
        end
        if (issue) begin
          rd_pend_d = 1'b1;
          rd_last_d = (left_q == LeftW'(1));
          left_d    = left_q - 1'b1;
          raddr_d   = (raddr_q == AddrW'(WindowLen - 1)) ? '0 : raddr_q + 1'b1;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      left_q      <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q   <= state_d;
      left_q    <= left_d;
      rd_pend_q <= rd_pend_d;
      rd_last_q <= rd_last_d;
      if (move) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    if (pop_o) begin
      store[head_i.addr] <= head_i.sample;
    end
    if (issue) begin
      rdata_q <= store[raddr_q];
    end
    if (move) begin
      window_sample_o  <= rdata_q;
      last_of_window_o <= rd_last_q;
      average_value_o  <= rd_last_q ? quotient[AvgW-1:0] : '0;
    end
  end

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_IDLE |-> !rd_pend_q)
    else $error("read data left behind after drain");

  a_issue_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> rd_pend_q)
    else $error("issued read not held in read register");

  a_div_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> state_q == BK_DRAIN)
    else $error("divider running outside a drain");

  a_no_pop_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DRAIN |-> !pop_o)
    else $error("store written during drain");

endmodule

`default_nettype wire

// File: src/overlapping_window_framer.sv
// Top level of the overlapping window framer.
// Depends on ofr_pkg, ofr_front, ofr_fifo and ofr_back.
//
//   port group       dir  handshake                width
//   sample_i         in   in_valid_i / in_ready_o   16
//   window_sample_o,
//   last_of_window_o,
//   average_value_o  out  out_valid_o / out_ready_i 16 / 1 / 24
//
// Each sample is written into the store as the back end pops it; a hop that
// ends with a full window adds a drain of the whole window (one store read
// per cycle unless the output stalls, plus filling the read register),
// so the single store port sets the time a hop takes. The last result also
// waits on the serial divider, which starts with the drain.
// A four-entry queue lets the front keep taking samples during a drain;
// output stalls hold the drain. Reset clears all control state and the
// value ring.
`timescale 1ns / 1ps
`default_nettype none

module overlapping_window_framer
  import ofr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] window_sample_o,
  output logic               last_of_window_o,
  output logic [AvgW-1:0]    average_value_o
);

  logic       push, full, pop, empty;
  ofr_entry_t push_data, head;

  ofr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ofr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  ofr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .window_sample_o  (window_sample_o),
    .last_of_window_o (last_of_window_o),
    .average_value_o  (average_value_o)
  );

endmodule

`default_nettype wire
